/* sv/largest_remainder_weight_normalizer_unit_assert.svh */
// Assertion macros for the largest remainder weight normalizer.
// Included by the controller and datapath modules; no other dependencies.
`ifndef LARGEST_REMAINDER_WEIGHT_NORMALIZER_UNIT_ASSERT_SVH
`define LARGEST_REMAINDER_WEIGHT_NORMALIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define LRWN_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds through reset.
`define LRWN_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRWN_ASSERT(label, clk, rstn, prop, msg)
`define LRWN_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* sv/lrwn_pkg.sv */
// Shared types and constants of the largest remainder weight normalizer.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package lrwn_pkg;

    localparam int NUM_WEIGHTS   = 4;
    localparam int IDX_BITS      = 2;
    localparam int TGT_BITS      = 16;
    localparam int ACC_BITS      = TGT_BITS + 1;
    // Dividing the target by the number of weights is a shift by this amount.
    localparam int QUARTER_SHIFT = 2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_START = 7'b0001000,
        ST_WAIT  = 7'b0010000,
        ST_FIX   = 7'b0100000,
        ST_PUB   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic pass;
        logic zero_err;
        logic subst;
        logic mul;
        logic div_start;
        logic store;
        logic bump;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic sum_eq;
        logic sum_zero;
        logic tgt_lt4;
        logic div_done;
        logic idx_last;
        logic acc_lt_tgt;
    } sts_t;

endpackage

`default_nettype wire

/* sv/lrwn_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; instantiated by lrwn_dpath.
`default_nettype none

module lrwn_div #(
    parameter int DW = 32,
    parameter int VW = 18
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quot,
    output logic [VW-1:0]      rem
);

    localparam int CW = $clog2(DW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;

    logic [VW:0]   trial;
    logic [VW+1:0] diff;
    logic          borrow;

    // The partial remainder stays below the divisor, so the shifted trial
    // value stays below twice the divisor.
    assign trial  = {rem_reg, quo_reg[DW-1]};
    assign diff   = {1'b0, trial} - {2'b00, divisor};
    assign borrow = diff[VW+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW - 1);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DW-2:0], ~borrow};
            rem_reg <= borrow ? trial[VW-1:0] : diff[VW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* sv/lrwn_dpath.sv */
// Datapath of the normalizer: weight and result registers, multiplier,
// remainder scan and output register. Uses lrwn_pkg and lrwn_div.
`default_nettype none
`include "largest_remainder_weight_normalizer_unit_assert.svh"

module lrwn_dpath #(
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire lrwn_pkg::cmd_t  cmd,
    output lrwn_pkg::sts_t       sts,
    input  wire logic [15:0]     s_weight_0,
    input  wire logic [15:0]     s_weight_1,
    input  wire logic [15:0]     s_weight_2,
    input  wire logic [15:0]     s_weight_3,
    input  wire logic [15:0]     s_target_total,
    output logic [15:0]          m_norm_0,
    output logic [15:0]          m_norm_1,
    output logic [15:0]          m_norm_2,
    output logic [15:0]          m_norm_3,
    output logic                 m_zero_sum_error
);

    localparam int TB    = lrwn_pkg::TGT_BITS;
    localparam int NW    = lrwn_pkg::NUM_WEIGHTS;
    localparam int IB    = lrwn_pkg::IDX_BITS;
    localparam int AB    = lrwn_pkg::ACC_BITS;
    localparam int QS    = lrwn_pkg::QUARTER_SHIFT;
    // Only the low weight bits count; substitute weights need TB-QS bits.
    localparam int W_EFF = (WEIGHT_BITS < TB) ? WEIGHT_BITS : TB;
    localparam int WREG  = (W_EFF > TB - QS) ? W_EFF : TB - QS;
    localparam int SUMW  = WREG + QS;
    localparam int PW    = WREG + TB;

    logic [WREG-1:0] w_in [NW];
    logic [SUMW-1:0] sum_in;

    logic [WREG-1:0] w_reg [NW];
    logic [SUMW-1:0] sum_reg;
    logic [TB-1:0]   tgt_reg;
    logic [PW-1:0]   prod_reg;
    logic [TB-1:0]   q_reg [NW];
    logic [SUMW-1:0] r_reg [NW];
    logic [AB-1:0]   acc_reg;
    logic [IB-1:0]   idx_reg;
    logic            err_reg;
    logic [TB-1:0]   norm_reg [NW];
    logic            norm_err_reg;

    logic [PW-1:0]   div_quot;
    logic [SUMW-1:0] div_rem;
    logic            div_done;
    logic [TB-1:0]   quot16;

    logic [IB-1:0]   best_idx;
    logic [SUMW-1:0] best_r;

    assign w_in[0] = WREG'(s_weight_0[W_EFF-1:0]);
    assign w_in[1] = WREG'(s_weight_1[W_EFF-1:0]);
    assign w_in[2] = WREG'(s_weight_2[W_EFF-1:0]);
    assign w_in[3] = WREG'(s_weight_3[W_EFF-1:0]);
    assign sum_in  = SUMW'(w_in[0]) + SUMW'(w_in[1]) + SUMW'(w_in[2]) + SUMW'(w_in[3]);

    lrwn_div #(
        .DW (PW),
        .VW (SUMW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (sum_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // The quotient never exceeds the target, so its low bits carry it all.
    assign quot16 = div_quot[TB-1:0];

    // Largest remainder, first index on a tie, index 0 when all are zero.
    always_comb begin
        best_idx = '0;
        best_r   = '0;
        for (int i = 0; i < NW; i++) begin
            if (r_reg[i] > best_r) begin
                best_r   = r_reg[i];
                best_idx = IB'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_reg <= '0;
            acc_reg <= '0;
            idx_reg <= '0;
            err_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                tgt_reg <= s_target_total;
                acc_reg <= '0;
                idx_reg <= '0;
                err_reg <= 1'b0;
            end
            if (cmd.zero_err) begin
                err_reg <= 1'b1;
            end
            if (cmd.store) begin
                acc_reg <= acc_reg + AB'(quot16);
                idx_reg <= idx_reg + IB'(1);
            end
            if (cmd.bump) begin
                acc_reg <= acc_reg + AB'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < NW; i++) begin
                w_reg[i] <= w_in[i];
            end
            sum_reg <= sum_in;
        end
        if (cmd.subst) begin
            for (int i = 0; i < NW; i++) begin
                w_reg[i] <= WREG'(tgt_reg >> QS);
            end
            sum_reg <= SUMW'((tgt_reg >> QS) << QS);
        end
        if (cmd.pass) begin
            for (int i = 0; i < NW; i++) begin
                q_reg[i] <= TB'(w_reg[i]);
            end
        end
        if (cmd.zero_err) begin
            for (int i = 0; i < NW; i++) begin
                q_reg[i] <= '0;
            end
        end
        if (cmd.mul) begin
            prod_reg <= PW'(w_reg[idx_reg]) * PW'(tgt_reg);
        end
        if (cmd.store) begin
            q_reg[idx_reg] <= quot16;
            r_reg[idx_reg] <= div_rem;
        end
        if (cmd.bump) begin
            q_reg[best_idx] <= q_reg[best_idx] + TB'(1);
            r_reg[best_idx] <= '0;
        end
        if (cmd.publish) begin
            for (int i = 0; i < NW; i++) begin
                norm_reg[i] <= q_reg[i];
            end
            norm_err_reg <= err_reg;
        end
    end

    assign sts.sum_eq     = (sum_reg == SUMW'(tgt_reg));
    assign sts.sum_zero   = (sum_reg == '0);
    assign sts.tgt_lt4    = ((tgt_reg >> QS) == '0);
    assign sts.div_done   = div_done;
    assign sts.idx_last   = (idx_reg == IB'(NW - 1));
    assign sts.acc_lt_tgt = (acc_reg < AB'(tgt_reg));

    assign m_norm_0         = norm_reg[0];
    assign m_norm_1         = norm_reg[1];
    assign m_norm_2         = norm_reg[2];
    assign m_norm_3         = norm_reg[3];
    assign m_zero_sum_error = norm_err_reg;

    `LRWN_ASSERT(a_acc_le_target, aclk, aresetn, acc_reg <= AB'(tgt_reg), "running total passed the target")
    `LRWN_ASSERT(a_rem_below_sum, aclk, aresetn, div_done |-> (div_rem < sum_reg), "remainder not below the weight sum")

endmodule

`default_nettype wire

/* sv/lrwn_ctrl.sv */
// Controller state machine of the normalizer; issues datapath commands.
// Uses lrwn_pkg types.
`default_nettype none
`include "largest_remainder_weight_normalizer_unit_assert.svh"

module lrwn_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire lrwn_pkg::sts_t sts,
    output lrwn_pkg::cmd_t      cmd
);

    lrwn_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            lrwn_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = lrwn_pkg::ST_CHECK;
                end
            end
            lrwn_pkg::ST_CHECK: begin
                priority if (sts.sum_eq) begin
                    cmd.pass   = 1'b1;
                    state_next = lrwn_pkg::ST_PUB;
                end else if (sts.sum_zero && sts.tgt_lt4) begin
                    cmd.zero_err = 1'b1;
                    state_next   = lrwn_pkg::ST_PUB;
                end else begin
                    cmd.subst  = sts.sum_zero;
                    state_next = lrwn_pkg::ST_MUL;
                end
            end
            lrwn_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = lrwn_pkg::ST_START;
            end
            lrwn_pkg::ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = lrwn_pkg::ST_WAIT;
            end
            lrwn_pkg::ST_WAIT: begin
                if (sts.div_done) begin
                    cmd.store  = 1'b1;
                    state_next = sts.idx_last ? lrwn_pkg::ST_FIX : lrwn_pkg::ST_MUL;
                end
            end
            lrwn_pkg::ST_FIX: begin
                if (sts.acc_lt_tgt) begin
                    cmd.bump = 1'b1;
                end else begin
                    state_next = lrwn_pkg::ST_PUB;
                end
            end
            lrwn_pkg::ST_PUB: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.publish = 1'b1;
                    state_next  = lrwn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lrwn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lrwn_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == lrwn_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

    `LRWN_ASSERT(a_publish_free, aclk, aresetn, cmd.publish |-> (!m_valid_reg || m_ready), "result overwritten before it was taken")
    `LRWN_ASSERT(a_done_in_wait, aclk, aresetn, sts.div_done |-> (state_reg == lrwn_pkg::ST_WAIT), "divider finished outside the wait state")
    `LRWN_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid_reg, "output valid survived reset")

endmodule

`default_nettype wire

/* sv/largest_remainder_weight_normalizer_unit.sv */
// Top level of the largest remainder weight normalizer.
// Depends on lrwn_pkg, lrwn_ctrl, lrwn_dpath and lrwn_div.
//
// Channel   Direction  Handshake          Payload
// s_        input      s_valid / s_ready  s_weight_0..3, s_target_total
// m_        output     m_valid / m_ready  m_norm_0..3, m_zero_sum_error
//
// One transaction is worked on at a time. Each weight is multiplied by the
// target and divided by the weight sum on a shared serial divider that
// retires one quotient bit per cycle. The internal weight width is the
// smaller of WEIGHT_BITS and 16, but at least 14. The passthrough and
// all-zero error cases skip the multiply and divide rounds. Reset is
// synchronous and active low and clears the control state and the target,
// running total, index and error registers, but not the weight, quotient,
// remainder or result registers. A finished result sits in an output register,
// so a new input transaction is taken while the result waits for m_ready; only
// the next result stalls if the previous one has still not been taken.
`default_nettype none

module largest_remainder_weight_normalizer_unit #(
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_weight_0,
    input  wire logic [15:0] s_weight_1,
    input  wire logic [15:0] s_weight_2,
    input  wire logic [15:0] s_weight_3,
    input  wire logic [15:0] s_target_total,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_norm_0,
    output logic [15:0]      m_norm_1,
    output logic [15:0]      m_norm_2,
    output logic [15:0]      m_norm_3,
    output logic             m_zero_sum_error
);

    // Commands flow from the state machine to the datapath; status flows back.
    lrwn_pkg::cmd_t cmd;
    lrwn_pkg::sts_t sts;

    // The controller sequences the check, the four multiply and divide
    // rounds, the remainder fix-up and the handoff to the output register.
    lrwn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the weights, quotients and remainders, the
    // multiplier, the serial divider and the result register.
    lrwn_dpath #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_weight_0       (s_weight_0),
        .s_weight_1       (s_weight_1),
        .s_weight_2       (s_weight_2),
        .s_weight_3       (s_weight_3),
        .s_target_total   (s_target_total),
        .m_norm_0         (m_norm_0),
        .m_norm_1         (m_norm_1),
        .m_norm_2         (m_norm_2),
        .m_norm_3         (m_norm_3),
        .m_zero_sum_error (m_zero_sum_error)
    );

endmodule

`default_nettype wire

/* dv/largest_remainder_weight_normalizer_unit_tb.sv */
// Self-checking testbench for largest_remainder_weight_normalizer_unit.
// It depends on lrwn_pkg and the unit under test. It drives directed and random weight
// sets and checks every result against a built-in apportionment predictor.
module largest_remainder_weight_normalizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = lrwn_pkg::NUM_WEIGHTS;
    localparam int RANDOM_COUNT = 1930;

    typedef logic [NW-1:0][15:0] weights_t;

    typedef struct packed {
        weights_t    w;
        logic [15:0] tgt;
    } request_t;

    typedef struct packed {
        weights_t norm;
        logic     err;
    } share_t;

    // The scoreboard predicts the shares for each accepted transaction and holds them
    // in order until the matching result transaction comes out of the block.
    class share_scoreboard;
        share_t      pending[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        // Largest-remainder apportionment of four weights onto a target total.
        function share_t apportion(weights_t w_in, logic [15:0] tgt);
            longint unsigned w[NW];
            longint unsigned q[NW];
            longint unsigned r[NW];
            longint unsigned sum;
            longint unsigned acc;
            longint unsigned prod;
            longint unsigned best_r;
            int best;
            share_t res;
            res = '0;
            sum = 0;
            for (int i = 0; i < NW; i++) begin
                w[i] = w_in[i];
                sum += w[i];
            end
            // If the weights already add up to the target, they pass through unchanged.
            if (sum == tgt) begin
                for (int i = 0; i < NW; i++) res.norm[i] = w_in[i];
                return res;
            end
            // If all weights are zero, each weight is replaced by a quarter of the target.
            if (sum == 0) begin
                for (int i = 0; i < NW; i++) w[i] = tgt / NW;
                sum = (tgt / NW) * NW;
                if (sum == 0) begin
                    res.err = 1'b1;
                    return res;
                end
            end
            acc = 0;
            for (int i = 0; i < NW; i++) begin
                prod = w[i] * tgt;
                q[i] = prod / sum;
                r[i] = prod % sum;
                acc += q[i];
            end
            // Each missing unit goes to the largest remainder. The lowest index wins a tie.
            for (int step = 0; step < NW && acc < tgt; step++) begin
                best = 0;
                best_r = 0;
                for (int i = 0; i < NW; i++) begin
                    if (r[i] > best_r) begin
                        best_r = r[i];
                        best = i;
                    end
                end
                q[best] += 1;
                r[best] = 0;
                acc += 1;
            end
            for (int i = 0; i < NW; i++) res.norm[i] = q[i][15:0];
            return res;
        endfunction

        function void note_request(request_t req);
            pending.push_back(apportion(req.w, req.tgt));
        endfunction

        function void check_result(share_t got);
            share_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, got norm %h err %b",
                         $time, got.norm, got.err);
                failures++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < NW; i++) begin
                if (got.norm[i] !== want.norm[i]) begin
                    $display("%0t: norm_%0d expected %0d, got %0d",
                             $time, i, want.norm[i], got.norm[i]);
                    failures++;
                end
            end
            if (got.err !== want.err) begin
                $display("%0t: zero_sum_error expected %b, got %b", $time, want.err, got.err);
                failures++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_weight_0;
    logic [15:0] s_weight_1;
    logic [15:0] s_weight_2;
    logic [15:0] s_weight_3;
    logic [15:0] s_target_total;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_norm_0;
    logic [15:0] m_norm_1;
    logic [15:0] m_norm_2;
    logic [15:0] m_norm_3;
    logic        m_zero_sum_error;

    // These are the percentages of cycles in which the sender holds back a transaction
    // or the receiver deasserts ready. The stimulus process changes them between phases.
    int unsigned send_gap_pct = 19;
    int unsigned take_gap_pct = 88;

    share_scoreboard ledger = new();

    largest_remainder_weight_normalizer_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_weight_0      (s_weight_0),
        .s_weight_1      (s_weight_1),
        .s_weight_2      (s_weight_2),
        .s_weight_3      (s_weight_3),
        .s_target_total  (s_target_total),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_norm_0        (m_norm_0),
        .m_norm_1        (m_norm_1),
        .m_norm_2        (m_norm_2),
        .m_norm_3        (m_norm_3),
        .m_zero_sum_error(m_zero_sum_error)
    );

    // The clock has a 10 ns period. Rising edges fall at 5 ns, 15 ns, and so on.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Ready changes only at the falling edge, so it is stable at every rising edge where
    // the block samples it. One assignment per step keeps the update order unambiguous.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= take_gap_pct);
    end

    // A result transaction is accepted at the rising edge where valid and ready are both
    // high. The outputs are read before the block's own updates for that edge land.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ledger.check_result({m_norm_3, m_norm_2, m_norm_1, m_norm_0, m_zero_sum_error});
        end
    end

    function automatic request_t make_request(int unsigned a, int unsigned b, int unsigned c,
                                              int unsigned d, int unsigned t);
        request_t req;
        req.w[0] = a[15:0];
        req.w[1] = b[15:0];
        req.w[2] = c[15:0];
        req.w[3] = d[15:0];
        req.tgt  = t[15:0];
        return req;
    endfunction

    // The largest share of the random mix is full-range weights. It also includes weight sets that
    // hit the pass-through path, the all-zero substitution, small values that give
    // ties, and weights stuck at the corners of their range.
    function automatic request_t random_request();
        request_t    req;
        int unsigned kind;
        int unsigned sum;
        kind = $urandom_range(99);
        sum = 0;
        for (int i = 0; i < NW; i++) req.w[i] = 16'($urandom);
        req.tgt = 16'($urandom);
        if (kind < 40) begin
            // The full-range values above are kept as they are.
        end else if (kind < 55) begin
            for (int i = 0; i < NW; i++) req.w[i] = 16'($urandom_range(15));
            req.tgt = 16'($urandom_range(40));
        end else if (kind < 65) begin
            for (int i = 0; i < NW; i++) begin
                req.w[i] = 16'($urandom_range(16383));
                sum += req.w[i];
            end
            req.tgt = sum[15:0];
        end else if (kind < 73) begin
            req.w = '0;
            req.tgt = 16'($urandom_range(1) ? $urandom_range(7) : $urandom_range(65535));
        end else if (kind < 85) begin
            for (int i = 0; i < NW; i++) begin
                if ($urandom_range(1)) req.w[i] = '0;
            end
        end else begin
            for (int i = 0; i < NW; i++) begin
                case ($urandom_range(3))
                    0: req.w[i] = 16'd0;
                    1: req.w[i] = 16'd1;
                    2: req.w[i] = 16'd65534;
                    default: req.w[i] = 16'd65535;
                endcase
            end
            if ($urandom_range(1)) req.tgt = 16'($urandom_range(4));
            else req.tgt = 16'(32'd65535 - $urandom_range(2));
        end
        return req;
    endfunction

    // This task presents one transaction after a random number of idle cycles. The
    // payload is held until the transaction is accepted. The task returns at the next
    // falling edge, so the following call drives from there.
    task automatic offer_request(input request_t req);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_weight_0     <= req.w[0];
        s_weight_1     <= req.w[1];
        s_weight_2     <= req.w[2];
        s_weight_3     <= req.w[3];
        s_target_total <= req.tgt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ledger.note_request(req);
        @(negedge aclk);
    endtask

    initial begin
        request_t    directed[$];
        int unsigned total;
        int unsigned sent;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_weight_0     <= '0;
        s_weight_1     <= '0;
        s_weight_2     <= '0;
        s_weight_3     <= '0;
        s_target_total <= '0;

        // The directed cases come first. They cover the all-zero cases, the pass-through
        // path, the corners of the range, and ties among the remainders.
        directed.push_back(make_request(0, 0, 0, 0, 0));
        directed.push_back(make_request(0, 0, 0, 0, 1));
        directed.push_back(make_request(0, 0, 0, 0, 2));
        directed.push_back(make_request(0, 0, 0, 0, 3));
        directed.push_back(make_request(0, 0, 0, 0, 4));
        directed.push_back(make_request(0, 0, 0, 0, 7));
        directed.push_back(make_request(0, 0, 0, 0, 65535));
        directed.push_back(make_request(65535, 65535, 65535, 65535, 65535));
        directed.push_back(make_request(65535, 65535, 65535, 65535, 0));
        directed.push_back(make_request(65535, 65535, 65535, 65535, 1));
        directed.push_back(make_request(1, 0, 0, 0, 65535));
        directed.push_back(make_request(65535, 0, 0, 0, 65535));
        directed.push_back(make_request(0, 0, 0, 65535, 0));
        directed.push_back(make_request(1, 1, 1, 0, 2));
        directed.push_back(make_request(1, 1, 1, 1, 3));
        directed.push_back(make_request(3, 3, 3, 3, 6));
        directed.push_back(make_request(2, 2, 0, 0, 3));
        directed.push_back(make_request(10, 20, 30, 40, 100));
        directed.push_back(make_request(1, 2, 3, 4, 65535));
        directed.push_back(make_request(40000, 30000, 0, 1, 12345));
        directed.push_back(make_request(0, 1, 0, 1, 65535));
        directed.push_back(make_request(21845, 21845, 21845, 0, 65534));

        // Reset is held once, at the start, and then released.
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Idling runs in three phases: first mostly a slow receiver, then mostly a slow
        // sender, and finally both sides at full rate.
        total = directed.size() + RANDOM_COUNT;
        sent = 0;
        foreach (directed[k]) begin
            offer_request(directed[k]);
            sent++;
        end
        while (sent < total) begin
            if (sent == total / 3) begin
                send_gap_pct = 88;
                take_gap_pct = 19;
            end else if (sent == (2 * total) / 3) begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end
            offer_request(random_request());
            sent++;
        end
        s_valid <= 1'b0;

        // Wait for the outstanding results to drain. The extra cycles afterward catch any
        // stray result transaction that the block might still produce.
        while (ledger.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (ledger.failures == 0) begin
            $display("PASS largest_remainder_weight_normalizer_unit");
        end else begin
            $display("FAIL largest_remainder_weight_normalizer_unit");
        end
        $finish;
    end

    // A normal run takes well under 5 ms. This watchdog ends a run that hangs.
    initial begin
        #20_000_000;
        $display("FAIL largest_remainder_weight_normalizer_unit");
        $finish;
    end

endmodule
